### sv/interval_reservation_table_macros.svh
// Assertion macros used by the interval reservation table datapath.
// Depends on nothing; define NO_ASSERTIONS to compile them away.
`ifndef INTERVAL_RESERVATION_TABLE_MACROS_SVH
`define INTERVAL_RESERVATION_TABLE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define IRT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("irt assertion failed");

`define IRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("irt assertion failed");

`else

`define IRT_ASSERT_SAME(label, clk, rst_n, ante, cons)

`define IRT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### sv/irt_pkg.sv
// Types, constants and codes of the interval reservation table.
// No dependencies.
package irt_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int TIME_W        = 32;
  localparam int OUT_CNT_W     = 7;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

  typedef logic [TIME_W-1:0]    time_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [OUT_CNT_W-1:0] out_cnt_t;

  typedef enum logic [1:0] {
    STAT_BOOKED  = 2'd0,
    STAT_OVERLAP = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } ctl_state_t;

  typedef struct packed {
    logic    load;
    logic    scan;
    logic    write;
    logic    respond;
    status_t status;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic scan_done;
    logic rd_pending;
    logic hit;
    logic full;
    logic out_free;
  } dp_stat_t;

endpackage

### sv/irt_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on irt_pkg.
interface irt_req_if;
  import irt_pkg::*;
  logic  valid;
  logic  ready;
  time_t start_time;
  time_t end_time;

  modport source (output valid, output start_time, output end_time, input ready);
  modport sink (input valid, input start_time, input end_time, output ready);
endinterface

interface irt_resp_if;
  import irt_pkg::*;
  logic     valid;
  logic     ready;
  status_t  status;
  out_cnt_t entries_used;

  modport source (output valid, output status, output entries_used, input ready);
  modport sink (input valid, input status, input entries_used, output ready);
endinterface

### sv/interval_reservation_table.sv
// Interval reservation table: books half-open intervals that overlap no stored one.
// A request is accepted only when the block is idle. It then reads the stored
// intervals one per cycle through the single read port of the slot memories,
// stopping early when an overlap is found or the interval is empty. The result
// waits in an output register, so the next request is accepted while it is held.
// Status: 0 booked, 1 overlap, 2 table full, 3 empty interval.
module interval_reservation_table
  import irt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  irt_req_if.sink     in_item,
  irt_resp_if.source  out_item
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;

  assign in_item.ready = in_ready;

  irt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_item.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  irt_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_start_time    (in_item.start_time),
    .in_end_time      (in_item.end_time),
    .out_valid        (out_item.valid),
    .out_ready        (out_item.ready),
    .out_status       (out_item.status),
    .out_entries_used (out_item.entries_used)
  );

endmodule

### sv/irt_ctrl.sv
// Sequencer of the interval reservation table: accept, scan, finish.
// Depends on irt_pkg; drives the datapath through dp_cmd_t.
module irt_ctrl
  import irt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd.load    = 1'b0;
    cmd.scan    = 1'b0;
    cmd.write   = 1'b0;
    cmd.respond = 1'b0;
    cmd.status  = STAT_BOOKED;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.empty || stat.hit) begin
          state_nxt = ST_FINISH;
        end else if (!stat.scan_done) begin
          cmd.scan = 1'b1;
        end else if (!stat.rd_pending) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (stat.empty) begin
          cmd.status = STAT_EMPTY;
        end else if (stat.hit) begin
          cmd.status = STAT_OVERLAP;
        end else if (stat.full) begin
          cmd.status = STAT_FULL;
        end else begin
          cmd.status = STAT_BOOKED;
        end
        if (stat.out_free) begin
          cmd.respond = 1'b1;
          cmd.write   = (cmd.status == STAT_BOOKED);
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### sv/irt_dp.sv
// Datapath of the interval reservation table: slot memories, scan compare,
// entry count and result register. Depends on irt_pkg and the macro header.
`include "interval_reservation_table_macros.svh"

module irt_dp
  import irt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat,
  input  time_t    in_start_time,
  input  time_t    in_end_time,
  output logic     out_valid,
  input  logic     out_ready,
  output status_t  out_status,
  output out_cnt_t out_entries_used
);

  time_t   slot_start [TABLE_ENTRIES];
  time_t   slot_end   [TABLE_ENTRIES];

  time_t   req_start_r, req_end_r;
  time_t   rd_start_r, rd_end_r;
  logic    rd_vld_r;
  logic    hit_r;
  cnt_t    idx_r;
  cnt_t    count_r;
  logic    out_valid_r;
  status_t out_status_r;
  out_cnt_t out_count_r;
  logic    overlap;

  assign overlap = (req_start_r < rd_end_r) && (rd_start_r < req_end_r);

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      slot_start[count_r[IDX_W-1:0]] <= req_start_r;
      slot_end[count_r[IDX_W-1:0]]   <= req_end_r;
    end
    rd_start_r <= slot_start[idx_r[IDX_W-1:0]];
    rd_end_r   <= slot_end[idx_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_start_r <= in_start_time;
      req_end_r   <= in_end_time;
    end
    if (cmd.respond) begin
      out_status_r <= cmd.status;
      out_count_r  <= cmd.write ? OUT_CNT_W'(count_r + cnt_t'(1)) : OUT_CNT_W'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r    <= 1'b0;
      hit_r       <= 1'b0;
      idx_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan;
      if (cmd.load) begin
        hit_r <= 1'b0;
        idx_r <= '0;
      end else begin
        if (rd_vld_r && overlap) begin
          hit_r <= 1'b1;
        end
        if (cmd.scan) begin
          idx_r <= idx_r + cnt_t'(1);
        end
      end
      if (cmd.write) begin
        count_r <= count_r + cnt_t'(1);
      end
      if (cmd.respond) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.empty      = (req_end_r <= req_start_r);
  assign stat.scan_done  = (idx_r == count_r);
  assign stat.rd_pending = rd_vld_r;
  assign stat.hit        = hit_r;
  assign stat.full       = (count_r == cnt_t'(TABLE_ENTRIES));
  assign stat.out_free   = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_entries_used = out_count_r;

  `IRT_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_r <= cnt_t'(TABLE_ENTRIES))
  `IRT_ASSERT_SAME(a_write_not_full, clk, rst_n, cmd.write, !stat.full && !hit_r)
  `IRT_ASSERT_SAME(a_no_result_overwrite, clk, rst_n, cmd.respond, stat.out_free)
  `IRT_ASSERT_NEXT(a_count_step, clk, rst_n, cmd.write, count_r == $past(count_r) + cnt_t'(1))

endmodule
